// ----- rtl/shs_pkg.sv -----
// Shared types, constants and round functions for the SHA-1 stream hasher.
`default_nettype none

package shs_pkg;

    // Input item: one message byte or a finish command
    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } req_t;

    // Result item: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        length_error;
    } rsp_t;

    // Operation codes
    localparam logic OpAppend = 1'b0;
    localparam logic OpFinish = 1'b1;

    // Block geometry
    localparam int MsgWords  = 16;
    localparam int HashWords = 5;

    localparam logic [2:0] HashLast   = 3'(HashWords - 1);
    localparam logic [2:0] HashSteps  = 3'(HashWords);
    localparam logic [3:0] MsgLast    = 4'(MsgWords - 1);
    localparam logic [6:0] RoundLast  = 7'd79;
    localparam logic [6:0] RoundMsg   = 7'(MsgWords);
    localparam logic [6:0] RoundPh1   = 7'd20;
    localparam logic [6:0] RoundPh2   = 7'd40;
    localparam logic [6:0] RoundPh3   = 7'd60;
    localparam logic [5:0] FillLast   = 6'd63;
    localparam logic [3:0] LenHiWord  = 4'd14;
    localparam logic [7:0] PadByte    = 8'h80;

    // Round groups of the compression
    typedef enum logic [1:0] {
        PH_CHOOSE  = 2'd0,
        PH_PARITY1 = 2'd1,
        PH_MAJ     = 2'd2,
        PH_PARITY2 = 2'd3
    } phase_t;

    // Controls from the sequencer to the round datapath
    typedef struct packed {
        logic   shift;
        logic   round;
        logic   use_msg;
        phase_t phase;
    } core_ctl_t;

    // Sequencer states
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PAD    = 8'b0000_0010,
        S_HLOAD  = 8'b0000_0100,
        S_ROUND  = 8'b0000_1000,
        S_HSTORE = 8'b0001_0000,
        S_OREAD  = 8'b0010_0000,
        S_OCAP   = 8'b0100_0000,
        S_OHOLD  = 8'b1000_0000
    } state_t;

    // Initial hash value of word idx
    function automatic logic [31:0] iv_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6745_2301;
            3'd1:    v = 32'hEFCD_AB89;
            3'd2:    v = 32'h98BA_DCFE;
            3'd3:    v = 32'h1032_5476;
            3'd4:    v = 32'hC3D2_E1F0;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input phase_t ph);
        logic [31:0] v;
        case (ph)
            PH_CHOOSE:  v = 32'h5A82_7999;
            PH_PARITY1: v = 32'h6ED9_EBA1;
            PH_MAJ:     v = 32'h8F1B_BCDC;
            PH_PARITY2: v = 32'hCA62_C1D6;
            default:    v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_f(input phase_t ph, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] v;
        case (ph)
            PH_CHOOSE: v = (b & c) | (~b & d);
            PH_MAJ:    v = (b & c) | (b & d) | (c & d);
            default:   v = b ^ c ^ d;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/shs_ram.sv -----
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module shs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/shs_core.sv -----
// SHA-1 round datapath: working variables and the 16-word schedule window.
`default_nettype none

module shs_core (
    input  wire logic              clk,
    input  wire shs_pkg::core_ctl_t ctl,
    input  wire logic [31:0]       din,
    input  wire logic [31:0]       msg_word,
    output      logic [31:0]       head
);

    import shs_pkg::*;

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [MsgWords];
    logic [31:0] sched;
    logic [31:0] wt;
    logic [31:0] tmp;

    // Schedule word for this round and the round sum
    always_comb
    begin
        sched = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wt    = ctl.use_msg ? msg_word : {sched[30:0], sched[31]};
        tmp   = {a_reg[26:0], a_reg[31:27]} + round_f(ctl.phase, b_reg, c_reg, d_reg)
              + e_reg + wt + round_k(ctl.phase);
    end

    // Round step, or shift for hash load and write-back
    always_ff @(posedge clk)
    begin
        if (ctl.round)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int i = 0; i < MsgWords - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[MsgWords-1] <= wt;
        end
        else if (ctl.shift)
        begin
            a_reg <= b_reg;
            b_reg <= c_reg;
            c_reg <= d_reg;
            d_reg <= e_reg;
            e_reg <= din;
        end
    end

    assign head = a_reg;

endmodule

`default_nettype wire

// ----- rtl/sha1_stream_hasher.sv -----
// Top level of the SHA-1 stream hasher: sequencer, block and hash memories.
//
//  channel | direction | payload        | transfer when
//  req     | in        | shs_pkg::req_t | req_valid & req_ready
//  rsp     | out       | shs_pkg::rsp_t | rsp_valid & rsp_ready
//
// Every fourth appended byte writes a word to the block RAM.
// A full block runs 5 hash reads, 80 rounds on one round unit and 5 write-backs.
// A finish writes the pad words (16 minus the word index of the fill), compresses
// once or twice, then gives each digest word through read, capture and hold states.
// Reset is immediate: hash words carry valid bits and read as the initial value
// until written; the block RAM needs no clearing. req_ready is low while busy.
`default_nettype none

module sha1_stream_hasher (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_ready,
    input  wire shs_pkg::req_t req,
    output      logic          rsp_valid,
    input  wire logic          rsp_ready,
    output      shs_pkg::rsp_t rsp
);

    import shs_pkg::*;

    // Control state
    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] count_reg, count_next;
    logic        ovf_reg, ovf_next;
    logic [4:0]  hvalid_reg, hvalid_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [6:0]  t_reg, t_next;
    logic [3:0]  widx_reg, widx_next;
    logic        finishing_reg, finishing_next;
    logic        extra_reg, extra_next;
    logic        pad_done_reg, pad_done_next;
    logic        rsp_valid_reg, rsp_valid_next;

    // Payload state
    logic [23:0] asm_reg, asm_next;
    logic        hsel_reg, hsel_next;
    logic [2:0]  hidx_reg, hidx_next;
    rsp_t        rsp_reg, rsp_next;

    // Memory ports
    logic        msg_we, msg_re;
    logic [3:0]  msg_waddr, msg_raddr;
    logic [31:0] msg_wdata, msg_rdata;
    logic        hash_we, hash_re;
    logic [2:0]  hash_waddr, hash_raddr;
    logic [31:0] hash_wdata, hash_rdata;

    core_ctl_t   core_ctl;
    logic [31:0] core_head;
    logic [31:0] hword;
    logic [31:0] pad_word;
    logic [63:0] len_bits;

    shs_ram #(.WIDTH(32), .DEPTH(MsgWords)) u_msg_ram (
        .clk   (clk),
        .we    (msg_we),
        .waddr (msg_waddr),
        .wdata (msg_wdata),
        .re    (msg_re),
        .raddr (msg_raddr),
        .rdata (msg_rdata)
    );

    shs_ram #(.WIDTH(32), .DEPTH(HashWords)) u_hash_ram (
        .clk   (clk),
        .we    (hash_we),
        .waddr (hash_waddr),
        .wdata (hash_wdata),
        .re    (hash_re),
        .raddr (hash_raddr),
        .rdata (hash_rdata)
    );

    shs_core u_core (
        .clk      (clk),
        .ctl      (core_ctl),
        .din      (hword),
        .msg_word (msg_rdata),
        .head     (core_head)
    );

    // Hash word read back; unwritten entries hold the initial value
    assign hword    = hsel_reg ? hash_rdata : iv_word(hidx_reg);
    assign len_bits = {count_reg, 3'b000};

    // First pad word: pending bytes, then the 0x80 marker
    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    pad_word = {PadByte, 24'h0};
            2'd1:    pad_word = {asm_reg[7:0], PadByte, 16'h0};
            2'd2:    pad_word = {asm_reg[15:0], PadByte, 8'h0};
            default: pad_word = {asm_reg[23:0], PadByte};
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        hvalid_next    = hvalid_reg;
        cnt_next       = cnt_reg;
        t_next         = t_reg;
        widx_next      = widx_reg;
        finishing_next = finishing_reg;
        extra_next     = extra_reg;
        pad_done_next  = pad_done_reg;
        rsp_valid_next = rsp_valid_reg;
        asm_next       = asm_reg;
        hsel_next      = hsel_reg;
        hidx_next      = hidx_reg;
        rsp_next       = rsp_reg;

        msg_we     = 1'b0;
        msg_waddr  = fill_reg[5:2];
        msg_wdata  = {asm_reg, req.data_byte};
        msg_re     = 1'b0;
        msg_raddr  = t_reg[3:0] + 4'd1;
        hash_we    = 1'b0;
        hash_waddr = hidx_reg;
        hash_wdata = hword + core_head;
        hash_re    = 1'b0;
        hash_raddr = cnt_reg;

        core_ctl.shift   = 1'b0;
        core_ctl.round   = 1'b0;
        core_ctl.use_msg = (t_reg < RoundMsg);
        if (t_reg < RoundPh1)
        begin
            core_ctl.phase = PH_CHOOSE;
        end
        else if (t_reg < RoundPh2)
        begin
            core_ctl.phase = PH_PARITY1;
        end
        else if (t_reg < RoundPh3)
        begin
            core_ctl.phase = PH_MAJ;
        end
        else
        begin
            core_ctl.phase = PH_PARITY2;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.op == OpAppend)
                    begin
                        // Bytes after a length wrap are dropped
                        if (!ovf_reg)
                        begin
                            asm_next   = {asm_reg[15:0], req.data_byte};
                            msg_we     = (fill_reg[1:0] == 2'd3);
                            fill_next  = fill_reg + 6'd1;
                            count_next = count_reg + 61'd1;
                            if (&count_reg)
                            begin
                                ovf_next = 1'b1;
                            end
                            if (fill_reg == FillLast)
                            begin
                                finishing_next = 1'b0;
                                cnt_next       = 3'd0;
                                state_next     = S_HLOAD;
                            end
                        end
                    end
                    else if (ovf_reg)
                    begin
                        rsp_next.digest_word  = 32'h0;
                        rsp_next.word_index   = 3'd0;
                        rsp_next.last_word    = 1'b1;
                        rsp_next.length_error = 1'b1;
                        rsp_valid_next        = 1'b1;
                        state_next            = S_OHOLD;
                    end
                    else
                    begin
                        finishing_next = 1'b1;
                        extra_next     = (fill_reg[5:3] == 3'b111);
                        pad_done_next  = 1'b0;
                        widx_next      = fill_reg[5:2];
                        state_next     = S_PAD;
                    end
                end
            end

            S_PAD:
            begin
                // One pad word per cycle up to the end of the block
                msg_we        = 1'b1;
                msg_waddr     = widx_reg;
                pad_done_next = 1'b1;
                if (!pad_done_reg)
                begin
                    msg_wdata = pad_word;
                end
                else if (!extra_reg && (widx_reg >= LenHiWord))
                begin
                    msg_wdata = widx_reg[0] ? len_bits[31:0] : len_bits[63:32];
                end
                else
                begin
                    msg_wdata = 32'h0;
                end
                if (widx_reg == MsgLast)
                begin
                    cnt_next   = 3'd0;
                    state_next = S_HLOAD;
                end
                else
                begin
                    widx_next = widx_reg + 4'd1;
                end
            end

            S_HLOAD:
            begin
                // Read hash words into the working variables
                if (cnt_reg != HashSteps)
                begin
                    hash_re   = 1'b1;
                    hsel_next = hvalid_reg[cnt_reg];
                    hidx_next = cnt_reg;
                end
                if (cnt_reg != 3'd0)
                begin
                    core_ctl.shift = 1'b1;
                end
                if (cnt_reg == HashSteps)
                begin
                    msg_re     = 1'b1;
                    msg_raddr  = 4'd0;
                    t_next     = 7'd0;
                    state_next = S_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end

            S_ROUND:
            begin
                core_ctl.round = 1'b1;
                msg_re         = (t_reg < 7'(MsgLast));
                if (t_reg == RoundLast)
                begin
                    cnt_next   = 3'd0;
                    state_next = S_HSTORE;
                end
                else
                begin
                    t_next = t_reg + 7'd1;
                end
            end

            S_HSTORE:
            begin
                // Read-add-write each hash word; reads run one ahead of writes
                if (cnt_reg != HashSteps)
                begin
                    hash_re   = 1'b1;
                    hsel_next = hvalid_reg[cnt_reg];
                    hidx_next = cnt_reg;
                end
                if (cnt_reg != 3'd0)
                begin
                    hash_we               = 1'b1;
                    hvalid_next[hidx_reg] = 1'b1;
                    core_ctl.shift        = 1'b1;
                end
                if (cnt_reg == HashSteps)
                begin
                    if (extra_reg)
                    begin
                        extra_next = 1'b0;
                        widx_next  = 4'd0;
                        state_next = S_PAD;
                    end
                    else if (finishing_reg)
                    begin
                        cnt_next   = 3'd0;
                        state_next = S_OREAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end

            S_OREAD:
            begin
                hash_re    = 1'b1;
                hsel_next  = hvalid_reg[cnt_reg];
                hidx_next  = cnt_reg;
                state_next = S_OCAP;
            end

            S_OCAP:
            begin
                rsp_next.digest_word  = hword;
                rsp_next.word_index   = cnt_reg;
                rsp_next.last_word    = (cnt_reg == HashLast);
                rsp_next.length_error = 1'b0;
                rsp_valid_next        = 1'b1;
                state_next            = S_OHOLD;
            end

            S_OHOLD:
            begin
                if (rsp_ready)
                begin
                    rsp_valid_next = 1'b0;
                    if (rsp_reg.last_word)
                    begin
                        // Back to the initial state for the next message
                        fill_next      = 6'd0;
                        count_next     = 61'd0;
                        ovf_next       = 1'b0;
                        hvalid_next    = 5'd0;
                        finishing_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 3'd1;
                        state_next = S_OREAD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= 6'd0;
            count_reg     <= 61'd0;
            ovf_reg       <= 1'b0;
            hvalid_reg    <= 5'd0;
            cnt_reg       <= 3'd0;
            t_reg         <= 7'd0;
            widx_reg      <= 4'd0;
            finishing_reg <= 1'b0;
            extra_reg     <= 1'b0;
            pad_done_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            hvalid_reg    <= hvalid_next;
            cnt_reg       <= cnt_next;
            t_reg         <= t_next;
            widx_reg      <= widx_next;
            finishing_reg <= finishing_next;
            extra_reg     <= extra_next;
            pad_done_reg  <= pad_done_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        asm_reg  <= asm_next;
        hsel_reg <= hsel_next;
        hidx_reg <= hidx_next;
        rsp_reg  <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
